// ===== design/lrt_pkg.sv =====
// Shared types and constants for the LRU recency tracker.
package lrt_pkg;

   // Default number of keys held in the recency stack.
   localparam int ENTRIES_DEFAULT = 16;

   // Width of one cache key.
   localparam int KEY_W = 16;

   // Depth of the command queue and of the result queue.
   localparam int QUEUE_DEPTH = 2;

   // Operation codes on the request channel.
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_EVICT  = 2'd1;
   localparam logic [1:0] OP_TOUCH  = 2'd2;
   localparam logic [1:0] OP_NOP    = 2'd3;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_FULL    = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   // Decoded command kinds handed from the front end to the stack.
   typedef enum logic [1:0] {
      CMD_INSERT,
      CMD_EVICT,
      CMD_TOUCH,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [KEY_W-1:0] key;
   } cmd_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      status_type       status;
   } rsp_type;

endpackage

// ===== design/lrt_front.sv =====
// Front end: accepts request transactions, decodes them and queues the commands.
module lrt_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [1:0]               req_operation,
   input  logic [lrt_pkg::KEY_W-1:0] req_key,
   output logic                     full,
   output logic                     cmd_valid,
   output lrt_pkg::cmd_type         cmd,
   input  logic                     cmd_take
);

   localparam int PTR_W = (lrt_pkg::QUEUE_DEPTH > 1) ? $clog2(lrt_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(lrt_pkg::QUEUE_DEPTH + 1);

   lrt_pkg::cmd_type   slot_ff [lrt_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   lrt_pkg::cmd_type   decoded;
   logic               do_push;
   logic               do_pop;

   // Decode the operation code into a command kind.
   always_comb begin
      decoded.key = req_key;
      unique case (req_operation)
         lrt_pkg::OP_INSERT: decoded.kind = lrt_pkg::CMD_INSERT;
         lrt_pkg::OP_EVICT:  decoded.kind = lrt_pkg::CMD_EVICT;
         lrt_pkg::OP_TOUCH:  decoded.kind = lrt_pkg::CMD_TOUCH;
         lrt_pkg::OP_NOP:    decoded.kind = lrt_pkg::CMD_NOP;
         default:            decoded.kind = lrt_pkg::CMD_NOP;
      endcase
   end

   assign full      = (count_ff == CNT_W'(lrt_pkg::QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_take && cmd_valid;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(lrt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(lrt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Command storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// ===== design/lrt_stack.sv =====
// Back end: parallel compare-and-shift recency stack; one command per cycle unless rsp_full.
module lrt_stack #(
   parameter int ENTRIES = lrt_pkg::ENTRIES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               cmd_valid,
   input  lrt_pkg::cmd_type                   cmd,
   output logic                               cmd_take,
   input  logic                               rsp_full,
   output lrt_pkg::rsp_type                   rsp,
   output logic [$clog2(ENTRIES+1)-1:0]       occupancy
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int OCC_W = $clog2(ENTRIES + 1);

   logic [lrt_pkg::KEY_W-1:0] keys_ff [ENTRIES];
   logic [lrt_pkg::KEY_W-1:0] keys_in [ENTRIES];
   logic [OCC_W-1:0]          occ_ff, occ_in;
   logic [ENTRIES-1:0]        match;
   logic [ENTRIES-1:0]        hit_below;
   logic                      found;
   logic                      is_full;
   logic                      is_empty;
   logic [OCC_W-1:0]          occ_dec;
   logic [IDX_W-1:0]          lru_idx;

   assign cmd_take  = cmd_valid && !rsp_full;
   assign occupancy = occ_ff;
   assign is_full   = (occ_ff == OCC_W'(ENTRIES));
   assign is_empty  = (occ_ff == '0);
   assign occ_dec   = occ_ff - 1'b1;
   assign lru_idx   = occ_dec[IDX_W-1:0];

   // Every valid cell compares its key with the command key.
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = (OCC_W'(i) < occ_ff) && (keys_ff[i] == cmd.key);
      end
   end

   assign found = |match;

   // A cell shifts on touch only if no match sits at a more recent position.
   always_comb begin
      logic [ENTRIES-1:0] lower;
      for (int i = 0; i < ENTRIES; i++) begin
         for (int j = 0; j < ENTRIES; j++) begin
            lower[j] = (j < i);
         end
         hit_below[i] = |(match & lower);
      end
   end

   // Next state of the stack and the result of the command.
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         keys_in[i] = keys_ff[i];
      end
      occ_in     = occ_ff;
      rsp.key    = '0;
      rsp.status = lrt_pkg::ST_OK;
      case (cmd.kind)
         lrt_pkg::CMD_INSERT: begin
            if (is_full) begin
               rsp.status = lrt_pkg::ST_FULL;
            end else begin
               keys_in[0] = cmd.key;
               for (int i = 1; i < ENTRIES; i++) begin
                  keys_in[i] = keys_ff[i-1];
               end
               occ_in = occ_ff + 1'b1;
            end
         end
         lrt_pkg::CMD_EVICT: begin
            if (is_empty) begin
               rsp.status = lrt_pkg::ST_EMPTY;
            end else begin
               rsp.key = keys_ff[lru_idx];
               occ_in  = occ_dec;
            end
         end
         lrt_pkg::CMD_TOUCH: begin
            if (!found) begin
               rsp.status = lrt_pkg::ST_MISSING;
            end else begin
               keys_in[0] = cmd.key;
               for (int i = 1; i < ENTRIES; i++) begin
                  if (!hit_below[i]) begin
                     keys_in[i] = keys_ff[i-1];
                  end
               end
            end
         end
         default: begin
            rsp.status = lrt_pkg::ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else if (cmd_take) begin
         occ_ff <= occ_in;
      end
   end

   // Key cells are undefined until written and need no reset.
   always_ff @(posedge clock) begin
      if (cmd_take) begin
         for (int i = 0; i < ENTRIES; i++) begin
            keys_ff[i] <= keys_in[i];
         end
      end
   end

endmodule

// ===== design/lrt_rsp_queue.sv =====
// Result queue that holds finished results until the receiver pops them.
module lrt_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  lrt_pkg::rsp_type wr_data,
   output logic             rsp_full,
   output logic             empty,
   input  logic             pop,
   output lrt_pkg::rsp_type rd_data
);

   localparam int PTR_W = (lrt_pkg::QUEUE_DEPTH > 1) ? $clog2(lrt_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(lrt_pkg::QUEUE_DEPTH + 1);

   lrt_pkg::rsp_type   slot_ff [lrt_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign rsp_full = (count_ff == CNT_W'(lrt_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign rd_data  = slot_ff[rd_ptr_ff];
   assign do_push  = wr_en && !rsp_full;
   assign do_pop   = pop && !empty;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(lrt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(lrt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Result storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== design/lru_recency_tracker.sv =====
// Top level of the LRU recency tracker: command queue, recency stack and result queue.
//
// The block keeps up to ENTRIES cache keys in recency order, most recent first.
// Requests arrive as a queue: a transaction is taken at a clock edge with push high
// and full low. req_operation selects insert (0), evict least recent (1), touch (2);
// code 3 does nothing and reports ok. Every request gives exactly one result.
// Results leave as a queue: while empty is low the oldest result sits on
// rsp_result_key and rsp_status, and it is taken at an edge with pop high.
// Status is 0 ok, 1 evict on empty, 2 insert when full, 3 touch not found;
// rsp_result_key carries the evicted key on a good evict and is zero otherwise.
// Requests are registered in the command queue, results in the result queue. The stack
// compares and shifts all cells combinationally: one request per cycle while pop is high.
// A two-entry command queue feeds the stack and a two-entry result queue drains
// it; when pop is held low the result queue fills, the stack stops, and full rises
// once the command queue is also full. Reset clears both queues and the occupancy
// count; no clearing pass is needed, so requests are taken right after reset.
module lru_recency_tracker #(
   parameter int ENTRIES = lrt_pkg::ENTRIES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic [1:0]                req_operation,
   input  logic [lrt_pkg::KEY_W-1:0] req_key,
   output logic                      empty,
   input  logic                      pop,
   output logic [lrt_pkg::KEY_W-1:0] rsp_result_key,
   output logic [1:0]                rsp_status
);

   localparam int OCC_W = $clog2(ENTRIES + 1);

   logic             cmd_valid;
   lrt_pkg::cmd_type cmd;
   logic             cmd_take;
   logic             rsp_full;
   lrt_pkg::rsp_type stack_rsp;
   lrt_pkg::rsp_type head_rsp;
   logic [OCC_W-1:0] occupancy;

   // Request decode and command queue.
   lrt_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .req_operation (req_operation),
      .req_key       (req_key),
      .full          (full),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_take      (cmd_take)
   );

   // Recency stack.
   lrt_stack #(
      .ENTRIES (ENTRIES)
   ) u_stack (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .rsp_full  (rsp_full),
      .rsp       (stack_rsp),
      .occupancy (occupancy)
   );

   // Result queue.
   lrt_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (cmd_take),
      .wr_data  (stack_rsp),
      .rsp_full (rsp_full),
      .empty    (empty),
      .pop      (pop),
      .rd_data  (head_rsp)
   );

   assign rsp_result_key = head_rsp.key;
   assign rsp_status     = head_rsp.status;

   // The occupancy count never passes the stack size.
   assert property (@(posedge clock) disable iff (reset) occupancy <= OCC_W'(ENTRIES))
      else $error("occupancy exceeds the stack size");

   // Any result other than ok carries a zero key.
   assert property (@(posedge clock) disable iff (reset)
      (cmd_take && stack_rsp.status != lrt_pkg::ST_OK) |-> stack_rsp.key == '0)
      else $error("failed command returned a nonzero key");

   // The stack only takes a command while one is queued and there is room for its result.
   assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> (cmd_valid && !rsp_full))
      else $error("stack took a command without a queued command or result room");

   // Occupancy moves by at most one per command and holds when no command is taken.
   assert property (@(posedge clock) disable iff (reset)
      !cmd_take |=> $stable(occupancy))
      else $error("occupancy changed without a command");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the LRU recency tracker.
`timescale 1ns / 100ps

// Recency-stack predictor and result checker.
class lru_scoreboard;
   logic [lrt_pkg::KEY_W-1:0] stack_keys [lrt_pkg::ENTRIES_DEFAULT];
   int unsigned               depth = 0;
   lrt_pkg::rsp_type          pending [$];
   int unsigned               mismatches = 0;

   // Apply one accepted request to the predicted stack and queue its result.
   function void note_request(logic [1:0] op, logic [lrt_pkg::KEY_W-1:0] key);
      lrt_pkg::rsp_type want;
      int               hit;
      want.key    = '0;
      want.status = lrt_pkg::ST_OK;
      hit         = -1;
      case (op)
         lrt_pkg::OP_INSERT: begin
            if (depth >= lrt_pkg::ENTRIES_DEFAULT) begin
               want.status = lrt_pkg::ST_FULL;
            end else begin
               for (int i = depth; i > 0; i--) stack_keys[i] = stack_keys[i-1];
               stack_keys[0] = key;
               depth++;
            end
         end
         lrt_pkg::OP_EVICT: begin
            if (depth == 0) begin
               want.status = lrt_pkg::ST_EMPTY;
            end else begin
               depth--;
               want.key = stack_keys[depth];
            end
         end
         lrt_pkg::OP_TOUCH: begin
            // The most recent matching entry moves to the front.
            for (int i = 0; i < depth; i++) begin
               if (hit < 0 && stack_keys[i] == key) hit = i;
            end
            if (hit < 0) begin
               want.status = lrt_pkg::ST_MISSING;
            end else begin
               for (int i = hit; i > 0; i--) stack_keys[i] = stack_keys[i-1];
               stack_keys[0] = key;
            end
         end
         default: begin
         end
      endcase
      pending.push_back(want);
   endfunction

   // Compare one accepted result with the oldest prediction.
   function void check_response(logic [lrt_pkg::KEY_W-1:0] rkey, logic [1:0] st);
      lrt_pkg::rsp_type want;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result key=%h status=%0d", $time, rkey, st);
         mismatches++;
      end else begin
         want = pending.pop_front();
         if (rkey !== want.key) begin
            $display("%0t: result_key mismatch, expected %h, actual %h",
                     $time, want.key, rkey);
            mismatches++;
         end
         if (st !== want.status) begin
            $display("%0t: status mismatch, expected %s, actual %0d",
                     $time, want.status.name(), st);
            mismatches++;
         end
      end
   endfunction
endclass

module tb;

   localparam int DEPTH       = lrt_pkg::ENTRIES_DEFAULT;
   localparam int KEY_W       = lrt_pkg::KEY_W;
   localparam int RANDOM_REQS = 600;
   localparam int PHASE_LEN   = 40;
   localparam int DRAIN_LIMIT = 20000;

   // Directed opening: empty-store cases, unused code, duplicates, touches, drain.
   localparam int DIR_N = 14;
   localparam logic [1:0] DIR_OPS [DIR_N] = '{
      lrt_pkg::OP_EVICT, lrt_pkg::OP_TOUCH, lrt_pkg::OP_NOP, lrt_pkg::OP_INSERT,
      lrt_pkg::OP_INSERT, lrt_pkg::OP_INSERT, lrt_pkg::OP_TOUCH, lrt_pkg::OP_TOUCH,
      lrt_pkg::OP_TOUCH, lrt_pkg::OP_NOP, lrt_pkg::OP_EVICT, lrt_pkg::OP_EVICT,
      lrt_pkg::OP_EVICT, lrt_pkg::OP_EVICT};
   localparam logic [KEY_W-1:0] DIR_KEYS [DIR_N] = '{
      16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000,
      16'hFFFF, 16'hA5A5, 16'h5A5A, 16'h0000, 16'hFFFF, 16'h1234, 16'h8001};

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             push = 1'b0;
   logic             pop = 1'b0;
   logic [1:0]       req_operation = lrt_pkg::OP_NOP;
   logic [KEY_W-1:0] req_key = '0;
   logic             full;
   logic             empty;
   logic [KEY_W-1:0] rsp_result_key;
   logic [1:0]       rsp_status;

   lru_scoreboard sb = new;
   int            results_seen = 0;
   int            req_idle_pct = 20;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   lru_recency_tracker #(.ENTRIES(DEPTH)) DUT (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_operation  (req_operation),
      .req_key        (req_key),
      .empty          (empty),
      .pop            (pop),
      .rsp_result_key (rsp_result_key),
      .rsp_status     (rsp_status)
   );

   // Offer one request after an optional idle gap; return once it is accepted.
   task automatic send_request(input logic [1:0] op, input logic [KEY_W-1:0] key);
      int gap;
      gap = 0;
      if ($urandom_range(0, 99) < req_idle_pct) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
      end
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push          <= 1'b1;
      req_operation <= op;
      req_key       <= key;
      do @(posedge clock); while (full);
      sb.note_request(op, key);
   endtask

   // Result side: pop with random stalls and two long hold-offs to fill the block.
   initial begin : result_side
      int stall_left;
      int stall_pct;
      int rate_left;
      int hold_offs;
      stall_left = 0;
      stall_pct  = 0;
      rate_left  = 0;
      hold_offs  = 0;
      forever begin
         @(posedge clock);
         if (!reset && pop && !empty) begin
            sb.check_response(rsp_result_key, rsp_status);
            results_seen++;
         end
         if (rate_left == 0) begin
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 10;
               2: stall_pct = 30;
               default: stall_pct = 60;
            endcase
            rate_left = $urandom_range(50, 200);
         end else begin
            rate_left--;
         end
         if (stall_left > 0) begin
            stall_left--;
         end else if ((hold_offs == 0 && results_seen >= 40) ||
                      (hold_offs == 1 && results_seen >= 350)) begin
            stall_left = 80;
            hold_offs++;
         end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                       : $urandom_range(1, 3);
         end
         pop <= !reset && (stall_left == 0);
      end
   end

   // Request side: reset, directed opening, biased random phases, then drain.
   initial begin : request_side
      int               ins_pct;
      int               evi_pct;
      int               r;
      int               waited;
      logic [1:0]       op;
      logic [KEY_W-1:0] key;
      ins_pct = 0;
      evi_pct = 0;
      waited  = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_N; i++) send_request(DIR_OPS[i], DIR_KEYS[i]);

      for (int n = 0; n < RANDOM_REQS; n++) begin
         // Each phase leans toward filling, draining or a mix; the first one fills.
         if (n % PHASE_LEN == 0) begin
            r = (n == 0) ? 0 : $urandom_range(0, 2);
            case (r)
               0: begin ins_pct = 65; evi_pct = 10; end
               1: begin ins_pct = 15; evi_pct = 60; end
               default: begin ins_pct = 35; evi_pct = 30; end
            endcase
            case ($urandom_range(0, 3))
               0: req_idle_pct = 0;
               1: req_idle_pct = 10;
               2: req_idle_pct = 25;
               default: req_idle_pct = 50;
            endcase
         end
         r = $urandom_range(0, 99);
         if (r < ins_pct) op = lrt_pkg::OP_INSERT;
         else if (r < ins_pct + evi_pct) op = lrt_pkg::OP_EVICT;
         else if (r < 95) op = lrt_pkg::OP_TOUCH;
         else op = lrt_pkg::OP_NOP;
         key = KEY_W'($urandom);
         // Small key pool makes duplicates; touches mostly hit held keys.
         if (op == lrt_pkg::OP_INSERT && $urandom_range(0, 1) == 0) begin
            key = KEY_W'($urandom_range(0, 7));
         end else if (op == lrt_pkg::OP_TOUCH && sb.depth > 0 &&
                      $urandom_range(0, 9) < 7) begin
            key = sb.stack_keys[$urandom_range(0, sb.depth - 1)];
         end
         send_request(op, key);
      end
      push <= 1'b0;

      while (sb.pending.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (sb.pending.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
         sb.mismatches++;
      end
      if (sb.mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin : watchdog
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
